### hw/rtl/mdu_pkg.sv
// Shared widths, register map and types of the multiply/divide unit.
package mdu_pkg;

  localparam int MUL_W     = 16;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DVD_W     = 32;
  localparam int DVS_W     = 16;
  localparam int MUL_CNT_W = $clog2(MUL_W);
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;

  localparam logic [APB_ADDR_W-1:0] REG_SIGNED_MODE = APB_ADDR_W'(0);

  typedef enum logic {
    ACT_MUL = 1'b0,
    ACT_DIV = 1'b1
  } mdu_action_t;

  typedef struct packed {
    logic div_op;
    logic neg_res;
    logic neg_rem;
    logic div_zero;
  } mdu_job_t;

endpackage

### hw/rtl/mdu_mul.sv
// Bit-serial shift-and-add multiplier on unsigned magnitudes.
module mdu_mul
  import mdu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_W-1:0]  mcand,
  input  logic [MUL_W-1:0]  mplier,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PROD_W-1:0]    acc_r, acc_nxt;
  logic [PROD_W-1:0]    mcand_r, mcand_nxt;
  logic [MUL_W-1:0]     mplier_r, mplier_nxt;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      acc_nxt    = '0;
      mcand_nxt  = PROD_W'(mcand);
      mplier_nxt = mplier;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = {mcand_r[PROD_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[MUL_W-1:1]};
      cnt_nxt    = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MUL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

### hw/rtl/mdu_div.sv
// Bit-serial restoring divider on unsigned magnitudes.
module mdu_div
  import mdu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### hw/rtl/mul16_div32by16_unit.sv
// Multiply/divide unit top level: handshake, sign handling, register port.
//
// A request on the in_ channel is a 16x16 multiply (in_action 0) or a
// 32-by-16 divide (in_action 1); one result per request leaves on the out_
// channel as a 32-bit product or quotient and a 16-bit remainder. A multiply
// reports the remainder of the last divide. The signed_mode register at byte
// address 0 of the APB port selects two's complement or unsigned operation.
// Operands are reduced to magnitudes on acceptance and the result sign is
// applied on completion. A multiply and a divide both run in the bit-serial
// datapaths, one bit per cycle; a request occupies the unit from acceptance
// until its result enters the output register. One request is in flight at a
// time. The result sits in an output register, so a new request is taken
// while a finished result waits; if the receiver stalls, the next finished
// result holds in the unit until the register frees. Reset clears
// signed_mode, the held remainder and all valids.
module mul16_div32by16_unit
  import mdu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [DVD_W-1:0]      in_dividend_or_multiplicand,
  input  logic [MUL_W-1:0]      in_multiplier,
  input  logic [DVS_W-1:0]      in_divisor,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PROD_W-1:0]     out_result_word,
  output logic [DVS_W-1:0]      out_remainder_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic             signed_mode_r;
  logic [DVS_W-1:0] rem_hold_r, rem_hold_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PROD_W-1:0] out_res_r, out_res_nxt;
  mdu_job_t         job_r, job_nxt;
  logic [DVS_W-1:0] dvd_low_r, dvd_low_nxt;

  logic             accept;
  logic             mul_start, div_start;
  logic             mul_done, div_done;
  logic [PROD_W-1:0] product;
  logic [DVD_W-1:0] quotient;
  logic [DVS_W-1:0] remainder;

  logic             a_neg, b_neg, d_neg, s_neg;
  logic [MUL_W-1:0] a_mag, b_mag;
  logic [DVD_W-1:0] d_mag;
  logic [DVS_W-1:0] s_mag;
  logic [PROD_W-1:0] raw_res, fin_res;
  logic [DVS_W-1:0] fin_rem;
  logic             unload;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_SIGNED_MODE) ?
                  APB_DATA_W'(signed_mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == REG_SIGNED_MODE)) begin
      signed_mode_r <= pwdata[0];
    end
  end

  // Operand magnitudes
  assign a_neg = signed_mode_r & in_dividend_or_multiplicand[MUL_W-1];
  assign b_neg = signed_mode_r & in_multiplier[MUL_W-1];
  assign d_neg = signed_mode_r & in_dividend_or_multiplicand[DVD_W-1];
  assign s_neg = signed_mode_r & in_divisor[DVS_W-1];
  assign a_mag = a_neg ? (MUL_W'(0) - in_dividend_or_multiplicand[MUL_W-1:0])
                       : in_dividend_or_multiplicand[MUL_W-1:0];
  assign b_mag = b_neg ? (MUL_W'(0) - in_multiplier) : in_multiplier;
  assign d_mag = d_neg ? (DVD_W'(0) - in_dividend_or_multiplicand)
                       : in_dividend_or_multiplicand;
  assign s_mag = s_neg ? (DVS_W'(0) - in_divisor) : in_divisor;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign mul_start = accept && (in_action == ACT_MUL);
  assign div_start = accept && (in_action == ACT_DIV);

  mdu_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (a_mag),
    .mplier  (b_mag),
    .done    (mul_done),
    .product (product)
  );

  mdu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (d_mag),
    .divisor   (s_mag),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Sign fix-up of the finished result; a divide by zero gives a zero quotient and the low dividend half as remainder
  assign raw_res = job_r.div_op ? quotient : product;
  always_comb begin
    if (job_r.div_op && job_r.div_zero) begin
      fin_res = '0;
      fin_rem = dvd_low_r;
    end else begin
      fin_res = job_r.neg_res ? (PROD_W'(0) - raw_res) : raw_res;
      fin_rem = job_r.neg_rem ? (DVS_W'(0) - remainder) : remainder;
    end
  end

  assign unload = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    dvd_low_nxt   = dvd_low_r;
    rem_hold_nxt  = rem_hold_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          job_nxt.div_op   = (in_action == ACT_DIV);
          job_nxt.neg_res  = (in_action == ACT_DIV) ? (d_neg ^ s_neg)
                                                    : (a_neg ^ b_neg);
          job_nxt.neg_rem  = d_neg;
          job_nxt.div_zero = (in_divisor == '0);
          dvd_low_nxt      = in_dividend_or_multiplicand[DVS_W-1:0];
          state_nxt        = S_RUN;
        end
      end
      S_RUN: begin
        if ((job_r.div_op && div_done) || (!job_r.div_op && mul_done)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (unload) begin
          out_res_nxt   = fin_res;
          out_valid_nxt = 1'b1;
          if (job_r.div_op) begin
            rem_hold_nxt = fin_rem;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rem_hold_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rem_hold_r  <= rem_hold_nxt;
    end
    job_r     <= job_nxt;
    dvd_low_r <= dvd_low_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_word    = out_res_r;
  assign out_remainder_word = rem_hold_r;

endmodule

### dv/tb_top.sv
// Testbench for mul16_div32by16_unit: directed and random requests against a predictor.
module tb_top
  import mdu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PROD_W-1:0] result_word;
    logic [DVS_W-1:0]  remainder_word;
  } mdu_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_action = ACT_MUL;
  logic [DVD_W-1:0]      in_dividend_or_multiplicand = '0;
  logic [MUL_W-1:0]      in_multiplier = '0;
  logic [DVS_W-1:0]      in_divisor = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PROD_W-1:0]     out_result_word;
  logic [DVS_W-1:0]      out_remainder_word;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bit               mode_signed = 1'b0;
  logic [DVS_W-1:0] remainder_held = '0;
  bit               gaps_on = 1'b1;
  int               result_mismatches = 0;
  mdu_result_t      expected_results[$];

  mul16_div32by16_unit DUT (
    .clk                         (clk),
    .rst_n                       (rst_n),
    .in_valid                    (in_valid),
    .in_ready                    (in_ready),
    .in_action                   (in_action),
    .in_dividend_or_multiplicand (in_dividend_or_multiplicand),
    .in_multiplier               (in_multiplier),
    .in_divisor                  (in_divisor),
    .out_valid                   (out_valid),
    .out_ready                   (out_ready),
    .out_result_word             (out_result_word),
    .out_remainder_word          (out_remainder_word),
    .psel                        (psel),
    .penable                     (penable),
    .pwrite                      (pwrite),
    .paddr                       (paddr),
    .pwdata                      (pwdata),
    .prdata                      (prdata),
    .pready                      (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic mdu_result_t compute_result(mdu_action_t act, logic [DVD_W-1:0] dvd,
                                                 logic [MUL_W-1:0] mpy, logic [DVS_W-1:0] dvs);
    mdu_result_t      res;
    logic [DVD_W-1:0] ma;
    logic [DVD_W-1:0] mb;
    logic [DVD_W-1:0] mq;
    logic [DVD_W-1:0] mr;
    logic             na;
    logic             nb;
    if (act == ACT_MUL) begin
      if (mode_signed) begin
        res.result_word = $signed(dvd[15:0]) * $signed(mpy);
      end else begin
        res.result_word = {16'h0, dvd[15:0]} * {16'h0, mpy};
      end
    end else begin
      if (dvs == '0) begin
        mq = '0;
        mr = {16'h0, dvd[15:0]};
      end else begin
        na = mode_signed && dvd[31];
        nb = mode_signed && dvs[15];
        ma = na ? -dvd : dvd;
        mb = nb ? -{{16{dvs[15]}}, dvs} : {16'h0, dvs};
        mq = ma / mb;
        mr = ma % mb;
        if (na != nb) mq = -mq;
        if (na) mr = -mr;
      end
      res.result_word = mq;
      remainder_held = mr[15:0];
    end
    res.remainder_word = remainder_held;
    return res;
  endfunction

  always @(posedge clk) begin
    mdu_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: result_word %h remainder_word %h",
               out_result_word, out_remainder_word);
        result_mismatches++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_result_word !== exp_res.result_word) begin
          $error("result_word expected %h actual %h", exp_res.result_word, out_result_word);
          result_mismatches++;
        end
        if (out_remainder_word !== exp_res.remainder_word) begin
          $error("remainder_word expected %h actual %h", exp_res.remainder_word,
                 out_remainder_word);
          result_mismatches++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(compute_result(mdu_action_t'(in_action),
                                                in_dividend_or_multiplicand,
                                                in_multiplier, in_divisor));
    end
  end

  initial begin
    int stall;
    forever begin
      stall = gaps_on ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_request(mdu_action_t act, logic [DVD_W-1:0] dvd, logic [MUL_W-1:0] mpy,
                              logic [DVS_W-1:0] dvs);
    int gap;
    gap = gaps_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid                    <= 1'b1;
    in_action                   <= act;
    in_dividend_or_multiplicand <= dvd;
    in_multiplier               <= mpy;
    in_divisor                  <= dvs;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_signed_mode(bit mode);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_SIGNED_MODE;
    pwdata  <= APB_DATA_W'(mode);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    mode_signed = mode;
  endtask

  function automatic logic [DVD_W-1:0] pick_dividend();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return DVD_W'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return 16'h8000;
      4: return 16'h7FFF;
      5: return 16'($urandom_range(1, 15));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic test_unsigned_directed();
    write_signed_mode(1'b0);
    send_request(ACT_MUL, 32'hABCD_1234, 16'h0002, 16'h5A5A);
    send_request(ACT_MUL, 32'h5555_FFFF, 16'hFFFF, 16'h0000);
    send_request(ACT_MUL, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
    send_request(ACT_DIV, 32'hFFFF_FFFF, 16'h1234, 16'hFFFF);
    send_request(ACT_DIV, 32'hFFFF_FFFF, 16'h0000, 16'h0001);
    send_request(ACT_DIV, 32'h1234_5678, 16'hFFFF, 16'h0000);
    send_request(ACT_DIV, 32'h0000_0000, 16'h0000, 16'h0005);
    send_request(ACT_DIV, 32'h0000_0007, 16'h0000, 16'h0003);
    send_request(ACT_MUL, 32'hFFFF_8000, 16'h8000, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_signed_directed();
    write_signed_mode(1'b1);
    send_request(ACT_MUL, 32'h0000_8000, 16'h8000, 16'h0000);
    send_request(ACT_MUL, 32'h0000_8000, 16'h7FFF, 16'h0000);
    send_request(ACT_MUL, 32'h0000_FFFF, 16'hFFFF, 16'h0000);
    send_request(ACT_DIV, 32'h8000_0000, 16'h0000, 16'hFFFF);
    send_request(ACT_DIV, 32'hFFFF_FFF9, 16'h0000, 16'h0002);
    send_request(ACT_DIV, 32'h0000_0007, 16'h0000, 16'hFFFE);
    send_request(ACT_DIV, 32'hFFFF_FFF9, 16'h0000, 16'hFFFE);
    send_request(ACT_DIV, 32'h8000_ABCD, 16'h0000, 16'h0000);
    send_request(ACT_DIV, 32'h7FFF_FFFF, 16'h0000, 16'h8000);
    send_request(ACT_DIV, 32'h8000_0000, 16'h0000, 16'h7FFF);
    send_request(ACT_MUL, 32'h1234_7FFF, 16'h7FFF, 16'h0001);
    wait_drained();
  endtask

  task automatic test_random_mode(bit mode, int count);
    mdu_action_t act;
    write_signed_mode(mode);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      act = $urandom_range(0, 1) ? ACT_DIV : ACT_MUL;
      send_request(act, pick_dividend(), pick_half(), pick_half());
    end
    gaps_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unsigned_directed();
    test_signed_directed();
    test_random_mode(1'b0, 475);
    test_random_mode(1'b1, 475);
    test_random_mode(1'b0, 475);
    test_random_mode(1'b1, 475);
    if (result_mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/mdu_pkg.sv
hw/rtl/mdu_mul.sv
hw/rtl/mdu_div.sv
hw/rtl/mul16_div32by16_unit.sv
dv/tb_top.sv
